>>> rtl/encoder_pulse_speed_estimator_defines.svh
// ----------------------------------------------------------------------------
// encoder pulse speed estimator assertion macros
// shared property wrappers for the checker
// ----------------------------------------------------------------------------
`ifndef ENCODER_PULSE_SPEED_ESTIMATOR_DEFINES_SVH
`define ENCODER_PULSE_SPEED_ESTIMATOR_DEFINES_SVH

// checked only while out of reset
`define ESPE_ASSERT(label, clk, rst_n, prop, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) prop) else $error(msg);

// checked at every edge, reset included
`define ESPE_ASSERT_ALWAYS(label, clk, prop, msg) \
  label: assert property (@(posedge clk) prop) else $error(msg);

`endif

>>> rtl/espe_pkg.sv
// ----------------------------------------------------------------------------
// espe_pkg
// types, codes and constants of the encoder pulse speed estimator
// ----------------------------------------------------------------------------
package espe_pkg;

  localparam int unsigned EmaFracBits = 8;

  localparam int unsigned CoefW    = 17;
  localparam int unsigned CntW     = 6;
  localparam int unsigned QuoW     = 39;
  localparam int unsigned PeriodW  = 40;
  localparam int unsigned CfgIdxW  = 3;
  localparam int unsigned CfgDataW = 32;

  localparam int unsigned SectorQBits = 17;
  localparam int unsigned RpmQBits    = 31;
  localparam int unsigned OmegaQBits  = 39;

  localparam logic [63:0] RpmNum   = 64'd6000000000;
  localparam logic [63:0] OmegaNum = 64'd1608495438638;
  localparam logic [30:0] SatMax   = 31'h7FFF_FFFF;

  localparam logic [CoefW-1:0] AlphaOne = 17'd65536;

  localparam logic [CfgIdxW-1:0] CfgPulsesPerRev = 3'd0;
  localparam logic [CfgIdxW-1:0] CfgEmaAlpha     = 3'd1;
  localparam logic [CfgIdxW-1:0] CfgMinGap       = 3'd2;
  localparam logic [CfgIdxW-1:0] CfgTimeout      = 3'd3;
  localparam logic [CfgIdxW-1:0] CfgInvertSign   = 3'd4;

  localparam logic [15:0]      PprReset     = 16'd20;
  localparam logic [CoefW-1:0] AlphaReset   = 17'd13107;
  localparam logic [31:0]      MinGapReset  = 32'd0;
  localparam logic [31:0]      TimeoutReset = 32'd500000;
  localparam logic             InvertReset  = 1'b0;

  typedef enum logic [1:0] {
    OP_EDGE = 2'd0,
    OP_POLL = 2'd1,
    OP_ZERO = 2'd2,
    OP_NONE = 2'd3
  } op_e;

  typedef enum logic [1:0] {
    DIV_SECTOR = 2'd0,
    DIV_RPM    = 2'd1,
    DIV_OMEGA  = 2'd2
  } div_sel_e;

  typedef struct packed {
    logic load;
    logic edge_begin;
    logic poll;
    logic zero;
    logic ema_write;
    logic mul_start;
    logic d_write;
    logic div_rpm;
    logic rpm_write;
    logic div_om;
    logic om_write;
    logic out_load;
  } cmd_t;

  typedef struct packed {
    op_e  op;
    logic gap_ok;
    logic timed_out;
    logic ema_zero;
    logic mac_busy;
    logic div_busy;
  } sts_t;

endpackage

>>> rtl/encoder_pulse_speed_estimator.sv
// ----------------------------------------------------------------------------
// encoder_pulse_speed_estimator
// encoder period tachometer with ema smoothing, rpm and rad/s outputs
//
//   channel  direction  handshake                 payload
//   in       input      in_valid_i / in_ready_o   op_i, time_us_i
//   out      output     out_valid_o / out_ready_i edge_accepted_o .. edge_count_o
//   cfg      input      cfg_valid_i / cfg_ready_o cfg_index_i, cfg_data_i
//
// an edge that updates the speed runs a 17-step ema mac with the sector modulo
// alongside, then a 17-step multiply and the 31- and 39-step divides; polls,
// zero commands and filtered edges skip the arithmetic, and an edge whose ema is zero ends
// after the ema mac; one request is in flight; the result register lets the next one enter
// while a result waits on out_ready_i; configuration is taken every cycle, no clearing pass
// ----------------------------------------------------------------------------
module encoder_pulse_speed_estimator import espe_pkg::*; #(
  parameter int unsigned EMA_FRAC_BITS = EmaFracBits
) (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                in_valid_i,
  output logic                in_ready_o,
  input  logic [1:0]          op_i,
  input  logic [31:0]         time_us_i,
  output logic                out_valid_o,
  input  logic                out_ready_i,
  output logic                edge_accepted_o,
  output logic signed [31:0]  rpm_centi_o,
  output logic signed [31:0]  omega_milli_o,
  output logic [PeriodW-1:0]  period_ema_q8_o,
  output logic [15:0]         sector_index_o,
  output logic [31:0]         edge_count_o,
  input  logic                cfg_valid_i,
  output logic                cfg_ready_o,
  input  logic [CfgIdxW-1:0]  cfg_index_i,
  input  logic [CfgDataW-1:0] cfg_data_i
);

  cmd_t        cmd;
  sts_t        sts;
  logic [31:0] rpm, omega;

  espe_ctrl u_ctrl (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (in_valid_i),
    .in_ready_o  (in_ready_o),
    .out_valid_o (out_valid_o),
    .out_ready_i (out_ready_i),
    .sts_i       (sts),
    .cmd_o       (cmd)
  );

  espe_dp #(.EMA_FRAC_BITS(EMA_FRAC_BITS)) u_dp (
    .clk_i           (clk_i),
    .rst_ni          (rst_ni),
    .cfg_valid_i     (cfg_valid_i),
    .cfg_ready_o     (cfg_ready_o),
    .cfg_index_i     (cfg_index_i),
    .cfg_data_i      (cfg_data_i),
    .op_i            (op_i),
    .time_us_i       (time_us_i),
    .cmd_i           (cmd),
    .sts_o           (sts),
    .edge_accepted_o (edge_accepted_o),
    .rpm_o           (rpm),
    .omega_o         (omega),
    .period_ema_q8_o (period_ema_q8_o),
    .sector_index_o  (sector_index_o),
    .edge_count_o    (edge_count_o)
  );

  assign rpm_centi_o   = $signed(rpm);
  assign omega_milli_o = $signed(omega);

endmodule

>>> rtl/espe_mac.sv
// ----------------------------------------------------------------------------
// espe_mac
// bit-serial sum of two products, coefficient bits taken msb first
// ----------------------------------------------------------------------------
module espe_mac import espe_pkg::*; #(
  parameter int unsigned OW = 40
) (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             start_i,
  input  logic [OW-1:0]    opa_i,
  input  logic [CoefW-1:0] coefa_i,
  input  logic [OW-1:0]    opb_i,
  input  logic [CoefW-1:0] coefb_i,
  output logic             busy_o,
  output logic [OW+17:0]   acc_o
);

  localparam int unsigned AW = OW + 18;

  logic [CntW-1:0]  cnt_q, cnt_d;
  logic [CoefW-1:0] ca_q, cb_q;
  logic [OW-1:0]    opa_q, opb_q;
  logic [AW-1:0]    acc_q, acc_d, ta, tb;

  always_comb begin
    ta    = ca_q[CoefW-1] ? AW'(opa_q) : '0;
    tb    = cb_q[CoefW-1] ? AW'(opb_q) : '0;
    acc_d = (acc_q << 1) + ta + tb;
    cnt_d = cnt_q - CntW'(1);
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cnt_q <= '0;
    end else if (start_i) begin
      cnt_q <= CntW'(CoefW);
    end else if (cnt_q != '0) begin
      cnt_q <= cnt_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (start_i) begin
      ca_q  <= coefa_i;
      cb_q  <= coefb_i;
      opa_q <= opa_i;
      opb_q <= opb_i;
      acc_q <= '0;
    end else if (cnt_q != '0) begin
      ca_q  <= ca_q << 1;
      cb_q  <= cb_q << 1;
      acc_q <= acc_d;
    end
  end

  assign busy_o = (cnt_q != '0);
  assign acc_o  = acc_q;

endmodule

>>> rtl/espe_div.sv
// ----------------------------------------------------------------------------
// espe_div
// restoring divider, one quotient bit a cycle, with overflow precheck
// ----------------------------------------------------------------------------
module espe_div import espe_pkg::*; #(
  parameter int unsigned NW = 56
) (
  input  logic            clk_i,
  input  logic            rst_ni,
  input  logic            start_i,
  input  div_sel_e        sel_i,
  input  logic [NW-1:0]   num_i,
  input  logic [NW-1:0]   den_i,
  output logic            busy_o,
  output logic [QuoW-1:0] quo_o,
  output logic [NW-1:0]   rem_o,
  output logic            ovf_o
);

  logic [CntW-1:0] cnt_q, cnt_init;
  logic [NW-1:0]   rem_q, sh_q, den_q, rem_init, sh_init;
  logic [QuoW-1:0] quo_q;
  logic            ovf_q, take;
  logic [NW:0]     trial, diff;

  always_comb begin
    unique case (sel_i)
      DIV_SECTOR: begin
        rem_init = num_i >> SectorQBits;
        sh_init  = num_i << (NW - SectorQBits);
        cnt_init = CntW'(SectorQBits);
      end
      DIV_RPM: begin
        rem_init = num_i >> RpmQBits;
        sh_init  = num_i << (NW - RpmQBits);
        cnt_init = CntW'(RpmQBits);
      end
      DIV_OMEGA: begin
        rem_init = num_i >> OmegaQBits;
        sh_init  = num_i << (NW - OmegaQBits);
        cnt_init = CntW'(OmegaQBits);
      end
      default: begin
        rem_init = num_i >> SectorQBits;
        sh_init  = num_i << (NW - SectorQBits);
        cnt_init = CntW'(SectorQBits);
      end
    endcase
    trial = {rem_q, sh_q[NW-1]};
    diff  = trial - {1'b0, den_q};
    take  = (trial >= {1'b0, den_q});
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cnt_q <= '0;
    end else if (start_i) begin
      cnt_q <= cnt_init;
    end else if (cnt_q != '0) begin
      cnt_q <= cnt_q - CntW'(1);
    end
  end

  always_ff @(posedge clk_i) begin
    if (start_i) begin
      rem_q <= rem_init;
      sh_q  <= sh_init;
      den_q <= den_i;
      quo_q <= '0;
      ovf_q <= (rem_init >= den_i);
    end else if (cnt_q != '0) begin
      rem_q <= take ? diff[NW-1:0] : trial[NW-1:0];
      sh_q  <= sh_q << 1;
      quo_q <= {quo_q[QuoW-2:0], take};
    end
  end

  assign busy_o = (cnt_q != '0);
  assign quo_o  = quo_q;
  assign rem_o  = rem_q;
  assign ovf_o  = ovf_q;

endmodule

>>> rtl/espe_dp.sv
// ----------------------------------------------------------------------------
// espe_dp
// datapath: configuration, tachometer state, ema, speed math, result register
// ----------------------------------------------------------------------------
module espe_dp import espe_pkg::*; #(
  parameter int unsigned EMA_FRAC_BITS = EmaFracBits
) (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                cfg_valid_i,
  output logic                cfg_ready_o,
  input  logic [CfgIdxW-1:0]  cfg_index_i,
  input  logic [CfgDataW-1:0] cfg_data_i,
  input  logic [1:0]          op_i,
  input  logic [31:0]         time_us_i,
  input  cmd_t                cmd_i,
  output sts_t                sts_o,
  output logic                edge_accepted_o,
  output logic [31:0]         rpm_o,
  output logic [31:0]         omega_o,
  output logic [PeriodW-1:0]  period_ema_q8_o,
  output logic [15:0]         sector_index_o,
  output logic [31:0]         edge_count_o
);

  localparam int unsigned EW = 32 + EMA_FRAC_BITS;
  localparam int unsigned DW = EW + 16;
  localparam int unsigned AW = EW + 18;

  localparam logic [DW-1:0] RpmK   = DW'(RpmNum) << EMA_FRAC_BITS;
  localparam logic [DW-1:0] OmegaK = DW'(OmegaNum) << EMA_FRAC_BITS;

  function automatic logic [31:0] finish(input logic [30:0] v, input logic neg);
    logic [31:0] w;
    w = {1'b0, v};
    finish = neg ? (32'd0 - w) : w;
  endfunction

  // configuration
  logic [15:0]      ppr_q;
  logic [CoefW-1:0] alpha_q;
  logic [31:0]      min_gap_q, timeout_q;
  logic             invert_q;

  // tachometer state
  logic [1:0]    op_q;
  logic [31:0]   time_q, last_edge_q, count_q, last_upd_q, rpm_q, om_q;
  logic [EW-1:0] ema_q;
  logic [15:0]   sector_q;
  logic [DW-1:0] d_q;
  logic          accepted_q;

  // result register
  logic               out_acc_q;
  logic [31:0]        out_rpm_q, out_om_q, out_cnt_q;
  logic [PeriodW-1:0] out_period_q;
  logic [15:0]        out_sector_q;

  logic [31:0]      gap, since_upd;
  logic [CoefW-1:0] alpha_c, beta;
  logic [EW-1:0]    x, ema_new;
  logic [15:0]      modv;
  logic [AW-1:0]    acc, acc_rnd;
  logic [EW-1:0]    mac_opa, mac_opb;
  logic [CoefW-1:0] mac_ca, mac_cb;
  logic             mac_busy, div_busy, div_ovf, div_start;
  div_sel_e         div_sel;
  logic [DW-1:0]    div_num, div_den, div_rem;
  logic [QuoW-1:0]  div_quo;
  logic [16:0]      sector_inc;
  logic [QuoW:0]    om_rnd;
  logic [30:0]      rpm_v, om_v;
  logic [EW+39:0]   ema_wide;

  always_comb begin
    gap        = time_q - last_edge_q;
    since_upd  = time_q - last_upd_q;
    alpha_c    = (alpha_q > AlphaOne) ? AlphaOne : alpha_q;
    beta       = AlphaOne - alpha_c;
    x          = {gap, EMA_FRAC_BITS'(0)};
    modv       = (ppr_q == '0) ? 16'd1 : ppr_q;
    acc_rnd    = acc + AW'(32768);
    ema_new    = acc_rnd[16 +: EW];
    sector_inc = {1'b0, sector_q} + 17'd1;
    om_rnd     = {1'b0, div_quo} + (QuoW + 1)'(128);
    rpm_v      = div_ovf ? SatMax : div_quo[30:0];
    om_v       = (div_ovf || om_rnd[QuoW]) ? SatMax : om_rnd[38:8];
    ema_wide   = (EW + 40)'(ema_q);

    // ema step, seeding when the average is empty, or the ema times pulses per revolution
    if (cmd_i.edge_begin) begin
      if (ema_q == '0) begin
        mac_opa = x;
        mac_ca  = AlphaOne;
        mac_opb = x;
        mac_cb  = '0;
      end else begin
        mac_opa = ema_q;
        mac_ca  = beta;
        mac_opb = x;
        mac_cb  = alpha_c;
      end
    end else begin
      mac_opa = ema_q;
      mac_ca  = {1'b0, modv};
      mac_opb = ema_q;
      mac_cb  = '0;
    end

    div_start = cmd_i.edge_begin | cmd_i.div_rpm | cmd_i.div_om;
    priority if (cmd_i.div_rpm) begin
      div_sel = DIV_RPM;
      div_num = RpmK + (d_q >> 1);
      div_den = d_q;
    end else if (cmd_i.div_om) begin
      div_sel = DIV_OMEGA;
      div_num = OmegaK;
      div_den = d_q;
    end else begin
      div_sel = DIV_SECTOR;
      div_num = DW'(sector_inc);
      div_den = DW'(modv);
    end
  end

  espe_mac #(.OW(EW)) u_mac (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .start_i (cmd_i.edge_begin | cmd_i.mul_start),
    .opa_i   (mac_opa),
    .coefa_i (mac_ca),
    .opb_i   (mac_opb),
    .coefb_i (mac_cb),
    .busy_o  (mac_busy),
    .acc_o   (acc)
  );

  espe_div #(.NW(DW)) u_div (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .start_i (div_start),
    .sel_i   (div_sel),
    .num_i   (div_num),
    .den_i   (div_den),
    .busy_o  (div_busy),
    .quo_o   (div_quo),
    .rem_o   (div_rem),
    .ovf_o   (div_ovf)
  );

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      ppr_q     <= PprReset;
      alpha_q   <= AlphaReset;
      min_gap_q <= MinGapReset;
      timeout_q <= TimeoutReset;
      invert_q  <= InvertReset;
    end else if (cfg_valid_i) begin
      unique case (cfg_index_i)
        CfgPulsesPerRev: ppr_q     <= cfg_data_i[15:0];
        CfgEmaAlpha:     alpha_q   <= cfg_data_i[CoefW-1:0];
        CfgMinGap:       min_gap_q <= cfg_data_i;
        CfgTimeout:      timeout_q <= cfg_data_i;
        CfgInvertSign:   invert_q  <= cfg_data_i[0];
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      last_edge_q <= '0;
      ema_q       <= '0;
      count_q     <= '0;
      sector_q    <= '0;
      last_upd_q  <= '0;
      rpm_q       <= '0;
      om_q        <= '0;
      accepted_q  <= 1'b0;
    end else begin
      if (cmd_i.load) begin
        accepted_q <= 1'b0;
      end
      if (cmd_i.edge_begin) begin
        accepted_q  <= 1'b1;
        count_q     <= count_q + 32'd1;
        last_edge_q <= time_q;
      end
      if (cmd_i.poll && sts_o.timed_out) begin
        rpm_q <= '0;
        om_q  <= '0;
        ema_q <= '0;
      end
      if (cmd_i.zero) begin
        count_q     <= '0;
        last_edge_q <= '0;
        ema_q       <= '0;
        rpm_q       <= '0;
        om_q        <= '0;
        sector_q    <= '0;
      end
      if (cmd_i.ema_write) begin
        ema_q    <= ema_new;
        sector_q <= div_rem[15:0];
      end
      if (cmd_i.rpm_write) begin
        rpm_q <= finish(rpm_v, invert_q);
      end
      if (cmd_i.om_write) begin
        om_q       <= finish(om_v, invert_q);
        last_upd_q <= time_q;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.load) begin
      op_q   <= op_i;
      time_q <= time_us_i;
    end
    if (cmd_i.d_write) begin
      d_q <= acc[DW-1:0];
    end
    if (cmd_i.out_load) begin
      out_acc_q    <= accepted_q;
      out_rpm_q    <= rpm_q;
      out_om_q     <= om_q;
      out_period_q <= ema_wide[PeriodW-1:0];
      out_sector_q <= sector_q;
      out_cnt_q    <= count_q;
    end
  end

  always_comb begin
    sts_o.op        = op_e'(op_q);
    sts_o.gap_ok    = (min_gap_q == '0) || (gap >= min_gap_q);
    sts_o.timed_out = (since_upd > timeout_q);
    sts_o.ema_zero  = (ema_q == '0);
    sts_o.mac_busy  = mac_busy;
    sts_o.div_busy  = div_busy;
  end

  assign cfg_ready_o     = 1'b1;
  assign edge_accepted_o = out_acc_q;
  assign rpm_o           = out_rpm_q;
  assign omega_o         = out_om_q;
  assign period_ema_q8_o = out_period_q;
  assign sector_index_o  = out_sector_q;
  assign edge_count_o    = out_cnt_q;

endmodule

>>> rtl/espe_ctrl.sv
// ----------------------------------------------------------------------------
// espe_ctrl
// controller: sequences one request through ema, multiply and divisions
// ----------------------------------------------------------------------------
module espe_ctrl import espe_pkg::*; (
  input  logic clk_i,
  input  logic rst_ni,
  input  logic in_valid_i,
  output logic in_ready_o,
  output logic out_valid_o,
  input  logic out_ready_i,
  input  sts_t sts_i,
  output cmd_t cmd_o
);

  typedef enum logic [3:0] {
    S_IDLE,
    S_DECODE,
    S_EMA,
    S_EMA_CHK,
    S_MUL,
    S_RPM_GO,
    S_RPM,
    S_OM_GO,
    S_OM,
    S_DONE
  } state_e;

  state_e state_q, state_d;
  logic   out_valid_q, out_valid_d;

  always_comb begin
    state_d     = state_q;
    out_valid_d = out_valid_q;
    cmd_o       = '0;
    if (out_valid_q && out_ready_i) begin
      out_valid_d = 1'b0;
    end
    unique case (state_q)
      S_IDLE: begin
        if (in_valid_i) begin
          cmd_o.load = 1'b1;
          state_d    = S_DECODE;
        end
      end
      S_DECODE: begin
        priority if (sts_i.op == OP_EDGE && sts_i.gap_ok) begin
          cmd_o.edge_begin = 1'b1;
          state_d          = S_EMA;
        end else if (sts_i.op == OP_POLL) begin
          cmd_o.poll = 1'b1;
          state_d    = S_DONE;
        end else if (sts_i.op == OP_ZERO) begin
          cmd_o.zero = 1'b1;
          state_d    = S_DONE;
        end else begin
          state_d = S_DONE;
        end
      end
      S_EMA: begin
        if (!sts_i.mac_busy && !sts_i.div_busy) begin
          cmd_o.ema_write = 1'b1;
          state_d         = S_EMA_CHK;
        end
      end
      S_EMA_CHK: begin
        if (sts_i.ema_zero) begin
          state_d = S_DONE;
        end else begin
          cmd_o.mul_start = 1'b1;
          state_d         = S_MUL;
        end
      end
      S_MUL: begin
        if (!sts_i.mac_busy) begin
          cmd_o.d_write = 1'b1;
          state_d       = S_RPM_GO;
        end
      end
      S_RPM_GO: begin
        cmd_o.div_rpm = 1'b1;
        state_d       = S_RPM;
      end
      S_RPM: begin
        if (!sts_i.div_busy) begin
          cmd_o.rpm_write = 1'b1;
          state_d         = S_OM_GO;
        end
      end
      S_OM_GO: begin
        cmd_o.div_om = 1'b1;
        state_d      = S_OM;
      end
      S_OM: begin
        if (!sts_i.div_busy) begin
          cmd_o.om_write = 1'b1;
          state_d        = S_DONE;
        end
      end
      S_DONE: begin
        if (!out_valid_q || out_ready_i) begin
          cmd_o.out_load = 1'b1;
          out_valid_d    = 1'b1;
          state_d        = S_IDLE;
        end
      end
      default: state_d = S_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= S_IDLE;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      out_valid_q <= out_valid_d;
    end
  end

  assign in_ready_o  = (state_q == S_IDLE);
  assign out_valid_o = out_valid_q;

endmodule

>>> rtl/espe_chk.sv
// ----------------------------------------------------------------------------
// espe_chk
// port-level checker for the encoder pulse speed estimator
// ----------------------------------------------------------------------------
`include "encoder_pulse_speed_estimator_defines.svh"

module espe_chk (
  input logic               clk_i,
  input logic               rst_ni,
  input logic               in_valid_i,
  input logic               in_ready_o,
  input logic               out_valid_o,
  input logic               out_ready_i,
  input logic signed [31:0] rpm_centi_o,
  input logic signed [31:0] omega_milli_o
);

  logic        in_take, out_hold, sign_clash, at_min;
  logic [63:0] speeds;

  assign in_take    = in_valid_i && in_ready_o;
  assign out_hold   = out_valid_o && !out_ready_i;
  assign sign_clash = (rpm_centi_o > 0 && omega_milli_o < 0) ||
                      (rpm_centi_o < 0 && omega_milli_o > 0);
  assign at_min     = (rpm_centi_o == 32'sh8000_0000) || (omega_milli_o == 32'sh8000_0000);
  assign speeds     = {rpm_centi_o, omega_milli_o};

  `ESPE_ASSERT_ALWAYS(a_reset_idle, clk_i, !rst_ni |-> !out_valid_o, "result in reset")

  `ESPE_ASSERT(a_one_request, clk_i, rst_ni, in_take |=> !in_ready_o, "second request")

  `ESPE_ASSERT(a_held, clk_i, rst_ni, out_hold |=> out_valid_o && $stable(speeds), "held")

  `ESPE_ASSERT(a_signs_agree, clk_i, rst_ni, out_valid_o |-> !sign_clash, "opposite signs")

  `ESPE_ASSERT(a_saturated, clk_i, rst_ni, out_valid_o |-> !at_min, "speed beyond limit")

endmodule

bind encoder_pulse_speed_estimator espe_chk u_espe_chk (
  .clk_i         (clk_i),
  .rst_ni        (rst_ni),
  .in_valid_i    (in_valid_i),
  .in_ready_o    (in_ready_o),
  .out_valid_o   (out_valid_o),
  .out_ready_i   (out_ready_i),
  .rpm_centi_o   (rpm_centi_o),
  .omega_milli_o (omega_milli_o)
);
